// ===== rtl/iva_pkg.sv =====
// Shared constants, codes and types of the interrupt vector allocator.
package iva_pkg;

   // Default sizes of the vector table and of one priority window
   localparam int NUM_VECTORS_DEF = 256;
   localparam int WINDOW_SIZE_DEF = 16;

   // Field widths of one request and one response
   localparam int MODE_W = 2;
   localparam int PRIO_W = 4;
   localparam int CNT_W  = 5;
   localparam int VEC_W  = 8;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   // Window placement: priority times sixteen, never below the first device vector
   localparam int               PRIO_SHIFT          = 4;
   localparam logic [VEC_W-1:0] FIRST_DEVICE_VECTOR = 8'd32;

   // Request kinds
   localparam logic [MODE_W-1:0] MODE_SINGLE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONTIGUOUS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REGISTER   = 2'd2;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_CLAIM  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   // Claim of one vector in the vector store
   typedef struct packed {
      logic             en;
      logic [VEC_W-1:0] idx;
      logic             share;
   } store_wr_type;

endpackage

// ===== rtl/iva_vector_store.sv =====
// Occupied bits and shareable-flag memory of the interrupt vector table.
module iva_vector_store #(
   parameter int NUM_VECTORS = iva_pkg::NUM_VECTORS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [iva_pkg::VEC_W-1:0] rd_idx,
   input  iva_pkg::store_wr_type    wr,
   output logic                     used_rd,
   output logic                     share_rd
);
   import iva_pkg::*;

   localparam int              IDX_W     = $clog2(NUM_VECTORS);
   localparam logic [VEC_W:0]  NUM_LIMIT = (VEC_W+1)'(NUM_VECTORS);

   logic [NUM_VECTORS-1:0] used_ff;
   logic                   share_mem [NUM_VECTORS];
   logic                   share_rd_ff;
   logic                   rd_in_range;
   logic                   wr_in_range;

   assign rd_in_range = {1'b0, rd_idx} < NUM_LIMIT;
   assign wr_in_range = {1'b0, wr.idx} < NUM_LIMIT;

   // Occupied bits clear on reset; an entry that is not occupied reads as free
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr.en && wr_in_range) begin
         used_ff[wr.idx[IDX_W-1:0]] <= 1'b1;
      end
   end

   assign used_rd = rd_in_range ? used_ff[rd_idx[IDX_W-1:0]] : 1'b0;

   // Shareable flags: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         share_mem[wr.idx[IDX_W-1:0]] <= wr.share;
      end
      if (rd_in_range) begin
         share_rd_ff <= share_mem[rd_idx[IDX_W-1:0]];
      end else begin
         share_rd_ff <= 1'b0;
      end
   end

   assign share_rd = share_rd_ff;

endmodule

// ===== rtl/interrupt_vector_allocator.sv =====
// Top level of the interrupt vector allocator: request sequencer and response register.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | mode, priority_req, want_shared, run_length,
//          |     |                         | target_vector
//  rsp     | out | rsp_tvalid / rsp_tready | ok, base_vector
//
// One request at a time. Single and contiguous allocation scan the window one
// vector a cycle through the store's read port, then test one base a cycle and
// claim one vector a cycle. Registration skips scan and search and claims the
// target vector if it is in range. Reset clears all occupied bits at once.
// A response that is not taken holds the block; no request is accepted meanwhile.
module interrupt_vector_allocator #(
   parameter int NUM_VECTORS = iva_pkg::NUM_VECTORS_DEF,
   parameter int WINDOW_SIZE = iva_pkg::WINDOW_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode[1:0], priority_req[5:2], want_shared[6], run_length[11:7], target_vector[19:12]
   input  logic [iva_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // ok[0], base_vector[8:1]
   output logic [iva_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import iva_pkg::*;

   localparam int             OFF_W     = $clog2(WINDOW_SIZE + 1);
   localparam int             MIDX_W    = $clog2(WINDOW_SIZE);
   localparam logic [VEC_W:0] NUM_LIMIT = (VEC_W+1)'(NUM_VECTORS);

   // Request fields
   logic [MODE_W-1:0] req_mode;
   logic [PRIO_W-1:0] req_prio;
   logic              req_share;
   logic [CNT_W-1:0]  req_count;
   logic [VEC_W-1:0]  req_target;
   logic [VEC_W-1:0]  prio_start;

   assign req_mode   = req_tdata[1:0];
   assign req_prio   = req_tdata[5:2];
   assign req_share  = req_tdata[6];
   assign req_count  = req_tdata[11:7];
   assign req_target = req_tdata[19:12];
   assign prio_start = {req_prio, {PRIO_SHIFT{1'b0}}};

   state_type              state_ff, state_in;
   logic [VEC_W-1:0]       start_ff, start_in;
   logic                   share_ff, share_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [OFF_W-1:0]       off_ff, off_in;
   logic [OFF_W-1:0]       b_ff, b_in;
   logic [OFF_W-1:0]       j_ff, j_in;
   logic [WINDOW_SIZE-1:0] mask_ff, mask_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [MIDX_W-1:0]      pend_off_ff, pend_off_in;
   logic                   pend_fit_ff, pend_fit_in;
   logic                   pend_used_ff, pend_used_in;
   logic                   ok_ff, ok_in;
   logic [VEC_W-1:0]       base_ff, base_in;

   logic [VEC_W-1:0]       rd_vec;
   logic                   used_rd;
   logic                   share_rd;
   store_wr_type           store_wr;
   logic                   rd_in_range;
   logic [WINDOW_SIZE-1:0] need;
   logic [WINDOW_SIZE-1:0] shifted;
   logic [CNT_W:0]         run_end;
   logic                   run_fits;
   logic                   req_fire;

   // Vector store
   iva_vector_store #(
      .NUM_VECTORS(NUM_VECTORS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_vec),
      .wr      (store_wr),
      .used_rd (used_rd),
      .share_rd(share_rd)
   );

   // Store address: window vector while scanning, claimed vector otherwise
   assign rd_vec = (state_ff == ST_SCAN) ? start_ff + VEC_W'(off_ff) : base_ff + VEC_W'(j_ff);
   assign rd_in_range = {1'b0, rd_vec} < NUM_LIMIT;

   // Candidate test: run of count compatible vectors at offset b inside the window
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         need[i] = CNT_W'(i) < count_ff;
      end
   end
   assign shifted  = mask_ff >> b_ff;
   assign run_end  = (CNT_W+1)'(b_ff) + (CNT_W+1)'(count_ff);
   assign run_fits = run_end <= (CNT_W+1)'(WINDOW_SIZE);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      share_in      = share_ff;
      count_in      = count_ff;
      off_in        = off_ff;
      b_in          = b_ff;
      j_in          = j_ff;
      mask_in       = mask_ff;
      pend_valid_in = 1'b0;
      pend_off_in   = pend_off_ff;
      pend_fit_in   = pend_fit_ff;
      pend_used_in  = pend_used_ff;
      ok_in         = ok_ff;
      base_in       = base_ff;
      store_wr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               start_in = (prio_start < FIRST_DEVICE_VECTOR) ? FIRST_DEVICE_VECTOR : prio_start;
               share_in = req_share;
               off_in   = '0;
               b_in     = '0;
               j_in     = '0;
               ok_in    = 1'b0;
               base_in  = '0;
               priority if (req_mode == MODE_SINGLE) begin
                  count_in = CNT_W'(1);
                  state_in = ST_SCAN;
               end else if (req_mode == MODE_CONTIGUOUS) begin
                  count_in = req_count;
                  state_in = (req_count == '0) ? ST_DONE : ST_SCAN;
               end else if (req_mode == MODE_REGISTER) begin
                  count_in = CNT_W'(1);
                  base_in  = req_target;
                  state_in = ({1'b0, req_target} < NUM_LIMIT) ? ST_CLAIM : ST_DONE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // Issue one window vector a cycle; fold the previous one into the mask
            if (off_ff < OFF_W'(WINDOW_SIZE)) begin
               pend_valid_in = 1'b1;
               pend_off_in   = off_ff[MIDX_W-1:0];
               pend_fit_in   = rd_in_range;
               pend_used_in  = used_rd;
               off_in        = off_ff + OFF_W'(1);
            end else begin
               state_in = ST_SEARCH;
            end
            if (pend_valid_ff) begin
               mask_in[pend_off_ff] = pend_fit_ff && (!pend_used_ff || (share_rd && share_ff));
            end
         end
         ST_SEARCH: begin
            // Test one base a cycle, lowest first
            if (!run_fits) begin
               state_in = ST_DONE;
            end else if ((shifted & need) == need) begin
               base_in  = start_ff + VEC_W'(b_ff);
               state_in = ST_CLAIM;
            end else begin
               b_in = b_ff + OFF_W'(1);
            end
         end
         ST_CLAIM: begin
            // Claim one vector a cycle; a free vector records the request's flag
            store_wr.en    = !used_rd;
            store_wr.idx   = rd_vec;
            store_wr.share = share_ff;
            j_in           = j_ff + OFF_W'(1);
            if (CNT_W'(j_ff) + CNT_W'(1) == count_ff) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Working and response registers
   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      share_ff     <= share_in;
      count_ff     <= count_in;
      off_ff       <= off_in;
      b_ff         <= b_in;
      j_ff         <= j_in;
      mask_ff      <= mask_in;
      pend_off_ff  <= pend_off_in;
      pend_fit_ff  <= pend_fit_in;
      pend_used_ff <= pend_used_in;
      ok_ff        <= ok_in;
      base_ff      <= base_in;
   end

   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = {{(RSP_TDATA_W-VEC_W-1){1'b0}}, (ok_ff ? base_ff : {VEC_W{1'b0}}), ok_ff};

endmodule

// ===== rtl/iva_checker.sv =====
// Port-level checks of the interrupt vector allocator and their binding.
module iva_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [iva_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [iva_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import iva_pkg::*;

   // Held response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No request taken while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready with response pending");

   // An accepted request keeps the block busy for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting a request");

   // A failed response carries base vector zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == '0)
      else $error("failed response with nonzero base vector");

   // Nothing pending right after a reset cycle
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind interrupt_vector_allocator iva_checker u_iva_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
